// ===== sv/rar_pkg.sv =====
// Shared types and constants for the rational arithmetic reducer.
`default_nettype none

package rar_pkg;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_e;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_DIV_ZERO = 2'd1;
  localparam logic [1:0] STAT_DEN_ZERO = 2'd2;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL0 = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_COMB = 9'b000010000,
    S_SIGN = 9'b000100000,
    S_GCD  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_e;

  // sequencer to datapath
  typedef struct packed {
    logic start;
    logic mul0;
    logic mul1;
    logic mul2;
    logic comb;
    logic sign;
    logic gcd;
    logic div_load;
    logic div_step;
    logic out_load;
  } ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic in_err;
    logic gcd_done;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== sv/rar_ctrl.sv =====
// Sequencer for the multiply, GCD and division steps.
`default_nettype none

module rar_ctrl #(
  parameter int IN_WIDTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              out_free_i,
  input  wire rar_pkg::dp_stat_t stat_i,
  output rar_pkg::ctl_t          ctl_o
);

  localparam int MW = 2 * IN_WIDTH - 1;
  localparam int CW = $clog2(MW);

  rar_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    ctl_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      rar_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctl_o.start = 1'b1;
          state_d = stat_i.in_err ? rar_pkg::S_DONE : rar_pkg::S_MUL0;
        end
      end
      rar_pkg::S_MUL0: begin
        ctl_o.mul0 = 1'b1;
        state_d = rar_pkg::S_MUL1;
      end
      rar_pkg::S_MUL1: begin
        ctl_o.mul1 = 1'b1;
        state_d = rar_pkg::S_MUL2;
      end
      rar_pkg::S_MUL2: begin
        ctl_o.mul2 = 1'b1;
        state_d = rar_pkg::S_COMB;
      end
      rar_pkg::S_COMB: begin
        ctl_o.comb = 1'b1;
        state_d = rar_pkg::S_SIGN;
      end
      rar_pkg::S_SIGN: begin
        ctl_o.sign = 1'b1;
        state_d = rar_pkg::S_GCD;
      end
      rar_pkg::S_GCD: begin
        ctl_o.gcd = 1'b1;
        if (stat_i.gcd_done) begin
          ctl_o.div_load = 1'b1;
          cnt_d = '0;
          state_d = rar_pkg::S_DIV;
        end
      end
      rar_pkg::S_DIV: begin
        ctl_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(MW - 1)) begin
          state_d = rar_pkg::S_DONE;
        end
      end
      rar_pkg::S_DONE: begin
        if (out_free_i) begin
          ctl_o.out_load = 1'b1;
          state_d = rar_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rar_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rar_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rar_dp.sv =====
// Datapath: shared multiplier, binary GCD unit and two-lane restoring divider.
`default_nettype none

module rar_dp #(
  parameter int IN_WIDTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rar_pkg::ctl_t              ctl_i,
  output rar_pkg::dp_stat_t               stat_o,
  input  wire logic [1:0]                 action_i,
  input  wire logic signed [IN_WIDTH-1:0] a_num_i,
  input  wire logic [IN_WIDTH-2:0]        a_den_i,
  input  wire logic signed [IN_WIDTH-1:0] b_num_i,
  input  wire logic [IN_WIDTH-2:0]        b_den_i,
  output logic [31:0]                     res_num_o,
  output logic [30:0]                     res_den_o,
  output logic [1:0]                      status_o
);

  localparam int PW = 2 * IN_WIDTH;
  localparam int MW = PW - 1;
  localparam int KW = $clog2(MW);

  logic [1:0]                 act_q;
  logic signed [IN_WIDTH-1:0] an_q, bn_q;
  logic [IN_WIDTH-2:0]        ad_q, bd_q;
  logic [1:0]                 stat_q, stat_d;
  logic signed [PW-1:0]       p0_q, p1_q, p2_q;
  logic signed [PW-1:0]       n_q, d_q;
  logic [MW-1:0]              un_q, ud_q;
  logic [MW-1:0]              gu_q, gv_q;
  logic [KW-1:0]              k_q;
  logic                       neg_q;
  logic [MW-1:0]              rn_q, rd_q;

  // input checks, zero denominator takes priority
  always_comb begin
    if (a_den_i == '0 || b_den_i == '0) begin
      stat_d = rar_pkg::STAT_DEN_ZERO;
    end else if (action_i == rar_pkg::ACT_DIV && b_num_i == '0) begin
      stat_d = rar_pkg::STAT_DIV_ZERO;
    end else begin
      stat_d = rar_pkg::STAT_OK;
    end
  end

  assign stat_o.in_err   = (stat_d != rar_pkg::STAT_OK);
  assign stat_o.gcd_done = (gu_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stat_q <= rar_pkg::STAT_OK;
    end else if (ctl_i.start) begin
      stat_q <= stat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      act_q <= action_i;
      an_q  <= a_num_i;
      ad_q  <= a_den_i;
      bn_q  <= b_num_i;
      bd_q  <= b_den_i;
    end
  end

  // shared multiplier, one product per cycle
  logic signed [IN_WIDTH-1:0] ad_s, bd_s, mul_a, mul_b;
  logic signed [PW-1:0]       mul_p;

  assign ad_s = signed'({1'b0, ad_q});
  assign bd_s = signed'({1'b0, bd_q});

  always_comb begin
    if (ctl_i.mul0) begin
      mul_a = an_q;
      mul_b = (act_q == rar_pkg::ACT_MUL) ? bn_q : bd_s;
    end else if (ctl_i.mul1) begin
      mul_a = bn_q;
      mul_b = ad_s;
    end else begin
      mul_a = ad_s;
      mul_b = bd_s;
    end
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul0) p0_q <= mul_p;
    if (ctl_i.mul1) p1_q <= mul_p;
    if (ctl_i.mul2) p2_q <= mul_p;
  end

  // cross-product combine
  always_ff @(posedge clk_i) begin
    if (ctl_i.comb) begin
      case (rar_pkg::action_e'(act_q))
        rar_pkg::ACT_ADD: n_q <= p0_q + p1_q;
        rar_pkg::ACT_SUB: n_q <= p0_q - p1_q;
        default:          n_q <= p0_q;
      endcase
      d_q <= (act_q == rar_pkg::ACT_DIV) ? p1_q : p2_q;
    end
  end

  // magnitudes
  logic [PW-1:0] n_mag, d_mag;
  assign n_mag = n_q[PW-1] ? (PW'(0) - PW'(n_q)) : PW'(n_q);
  assign d_mag = d_q[PW-1] ? (PW'(0) - PW'(d_q)) : PW'(d_q);

  // binary GCD step
  logic [MW:0]   duv;
  logic [MW-1:0] dvu;
  logic          u_ge;

  assign duv  = {1'b0, gu_q} - {1'b0, gv_q};
  assign dvu  = gv_q - gu_q;
  assign u_ge = !duv[MW];

  // restoring division lanes, quotient bits shift into the dividend register
  logic [MW:0]   n_sh, d_sh;
  logic [MW+1:0] n_try, d_try;
  logic          n_ge, d_ge;

  assign n_sh  = {rn_q, un_q[MW-1]};
  assign d_sh  = {rd_q, ud_q[MW-1]};
  assign n_try = {1'b0, n_sh} - {2'b00, gv_q};
  assign d_try = {1'b0, d_sh} - {2'b00, gv_q};
  assign n_ge  = !n_try[MW+1];
  assign d_ge  = !d_try[MW+1];

  always_ff @(posedge clk_i) begin
    if (ctl_i.sign) begin
      un_q  <= n_mag[MW-1:0];
      ud_q  <= d_mag[MW-1:0];
      gu_q  <= n_mag[MW-1:0];
      gv_q  <= d_mag[MW-1:0];
      k_q   <= '0;
      neg_q <= n_q[PW-1] ^ d_q[PW-1];
    end else if (ctl_i.gcd) begin
      if (gu_q == '0) begin
        gu_q <= gu_q;
      end else if (!gu_q[0] && !gv_q[0]) begin
        gu_q <= gu_q >> 1;
        gv_q <= gv_q >> 1;
        k_q  <= k_q + 1'b1;
      end else if (!gu_q[0]) begin
        gu_q <= gu_q >> 1;
      end else if (!gv_q[0]) begin
        gv_q <= gv_q >> 1;
      end else if (u_ge) begin
        gu_q <= duv[MW-1:0];
      end else begin
        gv_q <= dvu;
      end
    end
    if (ctl_i.div_load) begin
      // common power of two leaves by shift, odd part by division
      un_q <= un_q >> k_q;
      ud_q <= ud_q >> k_q;
      rn_q <= '0;
      rd_q <= '0;
    end else if (ctl_i.div_step) begin
      un_q <= {un_q[MW-2:0], n_ge};
      ud_q <= {ud_q[MW-2:0], d_ge};
      rn_q <= n_ge ? n_try[MW-1:0] : n_sh[MW-1:0];
      rd_q <= d_ge ? d_try[MW-1:0] : d_sh[MW-1:0];
    end
  end

  // result formatting
  logic [63:0] mag64, num64, den64;
  logic        neg_fin;

  assign mag64   = 64'(un_q);
  assign den64   = 64'(ud_q);
  assign neg_fin = neg_q && (un_q != '0);
  assign num64   = neg_fin ? (64'd0 - mag64) : mag64;

  always_comb begin
    status_o = stat_q;
    if (stat_q != rar_pkg::STAT_OK) begin
      res_num_o = 32'd0;
      res_den_o = 31'd1;
    end else begin
      res_num_o = num64[31:0];
      res_den_o = den64[30:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/rational_arith_reduce.sv =====
// Top level of the rational arithmetic reducer with output register.
`default_nettype none

// Adds, subtracts, multiplies or divides two fractions and returns the result
// reduced to lowest terms with a positive denominator (zero as 0/1). One
// transaction is worked on at a time; input is stalled until its result has
// moved to the output register, which may still hold the previous result when
// the next transaction is taken. A valid transaction goes through setup
// (three products through one shared multiplier, combine, magnitude), then the
// binary GCD loop of one compare-subtract or shift per cycle, then 2*IN_WIDTH-1
// restoring-division steps and a handoff to the output register. A zero
// denominator or a divide by a zero fraction is flagged in status and
// returns 0/1.
module rational_arith_reduce #(
  parameter int IN_WIDTH = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 action_i,
  input  wire logic signed [IN_WIDTH-1:0] a_num_i,
  input  wire logic [IN_WIDTH-2:0]        a_den_i,
  input  wire logic signed [IN_WIDTH-1:0] b_num_i,
  input  wire logic [IN_WIDTH-2:0]        b_den_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [31:0]              res_num_o,
  output logic [30:0]                     res_den_o,
  output logic [1:0]                      status_o
);

  rar_pkg::ctl_t     ctl;
  rar_pkg::dp_stat_t dp_stat;
  logic              out_free;
  logic [31:0]       dp_num;
  logic [30:0]       dp_den;
  logic [1:0]        dp_status;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       res_num_q;
  logic [30:0]       res_den_q;
  logic [1:0]        status_q;

  assign out_free = !out_valid_q || !out_stall_i;

  rar_ctrl #(
    .IN_WIDTH (IN_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_free_i (out_free),
    .stat_i     (dp_stat),
    .ctl_o      (ctl)
  );

  rar_dp #(
    .IN_WIDTH (IN_WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (ctl),
    .stat_o    (dp_stat),
    .action_i  (action_i),
    .a_num_i   (a_num_i),
    .a_den_i   (a_den_i),
    .b_num_i   (b_num_i),
    .b_den_i   (b_den_i),
    .res_num_o (dp_num),
    .res_den_o (dp_den),
    .status_o  (dp_status)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.out_load) begin
      res_num_q <= dp_num;
      res_den_q <= dp_den;
      status_q  <= dp_status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = signed'(res_num_q);
  assign res_den_o   = res_den_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  // a flagged transaction always carries 0/1
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != rar_pkg::STAT_OK) |->
      (res_num_o == 32'sd0) && (res_den_o == 31'd1))
    else $error("flagged result is not 0/1");

  // one transaction in flight: busy right after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a transaction is in flight");

  // a new result only follows a busy cycle
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction in flight");
`endif

endmodule

`default_nettype wire
